>>> src/dmd4_pkg.sv
// ----------------------------------------------------------------------------
// dmd4_pkg
// Shared types and constants for the 4x4 depth minimum downsampler.
// ----------------------------------------------------------------------------
package dmd4_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;

  localparam int DEPTH_W     = 16;
  localparam int GROUPS_W    = 10;
  localparam int QUADS_W     = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int QROW_W      = $clog2(MAX_HEIGHT / 4);
  localparam int STORE_DEPTH = MAX_WIDTH / 4;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  localparam int MAX_GROUPS  = MAX_WIDTH / 8;
  localparam int MAX_QUADS   = MAX_HEIGHT / 4;

  localparam logic [GROUPS_W-1:0] GROUPS_RESET = GROUPS_W'(80);
  localparam logic [QUADS_W-1:0]  QUADS_RESET  = QUADS_W'(120);

  typedef logic [DEPTH_W-1:0] depth_t;

  localparam depth_t DEPTH_ALL_ONES = '1;

  typedef enum logic [0:0] {
    REG_WIDTH_IN_GROUPS = 1'b0,
    REG_HEIGHT_IN_QUADS = 1'b1
  } cfg_reg_t;

endpackage

>>> src/dmd4_if.sv
// ----------------------------------------------------------------------------
// dmd4 stream interfaces
// Valid/ready channels for incoming depth pixels and outgoing block minima.
// ----------------------------------------------------------------------------
interface dmd4_pixel_if import dmd4_pkg::*; ();
  logic   valid;
  logic   ready;
  depth_t depth_pixel;

  modport source (output valid, output depth_pixel, input ready);
  modport sink   (input valid, input depth_pixel, output ready);
endinterface

interface dmd4_block_if import dmd4_pkg::*; ();
  logic   valid;
  logic   ready;
  depth_t block_min;
  logic   last_of_frame;

  modport source (output valid, output block_min, output last_of_frame, input ready);
  modport sink   (input valid, input block_min, input last_of_frame, output ready);
endinterface

>>> src/depth_min_downsample_4x4.sv
// ----------------------------------------------------------------------------
// depth_min_downsample_4x4
// 4x4 minimum-nonzero pooling of a raster-order 16-bit depth stream.
// ----------------------------------------------------------------------------
// Takes one pixel request every cycle and returns one block minimum in the
// cycle after the last pixel of each 4x4 block; zero pixels are ignored and an
// all-zero block gives zero. Input ready drops only while a finished result is
// held unaccepted in the output register. Partial block minima for one row of
// blocks live in a 1024 x 16 line store; each block column is read on the
// pixel before its last and written on its last, so the store needs one read
// and one write port. Width (8-pixel groups) and height (4-row groups) are set
// via the write port by the user, only while the block is idle (not enforced).
module depth_min_downsample_4x4
  import dmd4_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [0:0]            reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  dmd4_pixel_if.sink            pixel,
  dmd4_block_if.source          block
);

  logic [GROUPS_W-1:0]    width_in_groups;
  logic [QUADS_W-1:0]     height_in_quads;
  depth_t                 horizontal_min;
  logic [COL_W-1:0]       column_count;
  logic [1:0]             row_in_quad;
  logic [QROW_W-1:0]      quad_row_count;

  depth_t                 partial_min_row [STORE_DEPTH];
  depth_t                 store_rd;

  logic                   out_valid;
  depth_t                 out_min;
  logic                   out_last;

  logic                   accept;
  logic [GROUPS_W-1:0]    groups_c;
  logic [QUADS_W-1:0]     quads_c;
  logic [COL_W:0]         last_col_wide;
  logic [COL_W-1:0]       last_col;
  logic [QUADS_W-1:0]     last_quad_wide;
  logic [QROW_W-1:0]      last_quad;
  logic                   row_end;
  logic                   frame_row;
  logic                   group_end;
  logic [STORE_IDX_W-1:0] store_idx;
  depth_t                 mapped;
  depth_t                 hmin_new;
  depth_t                 block_m;
  logic                   emit;

  assign accept      = pixel.valid && pixel.ready;
  assign pixel.ready = !out_valid || block.ready;

  always_comb begin
    if (width_in_groups == '0) begin
      groups_c = GROUPS_W'(1);
    end else if (width_in_groups > GROUPS_W'(MAX_GROUPS)) begin
      groups_c = GROUPS_W'(MAX_GROUPS);
    end else begin
      groups_c = width_in_groups;
    end
    if (height_in_quads == '0) begin
      quads_c = QUADS_W'(1);
    end else if (height_in_quads > QUADS_W'(MAX_QUADS)) begin
      quads_c = QUADS_W'(MAX_QUADS);
    end else begin
      quads_c = height_in_quads;
    end
  end

  assign last_col_wide  = (COL_W + 1)'({groups_c, 3'b000}) - (COL_W + 1)'(1);
  assign last_col       = last_col_wide[COL_W-1:0];
  assign last_quad_wide = quads_c - QUADS_W'(1);
  assign last_quad      = last_quad_wide[QROW_W-1:0];

  assign row_end   = column_count >= last_col;
  assign frame_row = quad_row_count >= last_quad;
  assign group_end = column_count[1:0] == 2'b11;
  assign store_idx = column_count[COL_W-1:2];

  // zero maps to all-ones so it never wins the minimum
  assign mapped   = pixel.depth_pixel - DEPTH_W'(1);
  assign hmin_new = (mapped < horizontal_min) ? mapped : horizontal_min;

  always_comb begin
    block_m = hmin_new;
    if (row_in_quad != 2'd0 && store_rd < hmin_new) begin
      block_m = store_rd;
    end
  end

  assign emit = group_end && row_in_quad == 2'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_groups <= GROUPS_RESET;
      height_in_quads <= QUADS_RESET;
    end else if (write_enable) begin
      case (cfg_reg_t'(reg_index))
        REG_WIDTH_IN_GROUPS: width_in_groups <= write_data[GROUPS_W-1:0];
        REG_HEIGHT_IN_QUADS: height_in_quads <= write_data[QUADS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_min <= DEPTH_ALL_ONES;
      column_count   <= '0;
      row_in_quad    <= '0;
      quad_row_count <= '0;
    end else if (accept) begin
      if (group_end || row_end) begin
        horizontal_min <= DEPTH_ALL_ONES;
      end else begin
        horizontal_min <= hmin_new;
      end
      if (row_end) begin
        column_count <= '0;
        if (row_in_quad == 2'd3) begin
          row_in_quad    <= '0;
          quad_row_count <= frame_row ? '0 : quad_row_count + QROW_W'(1);
        end else begin
          row_in_quad <= row_in_quad + 2'd1;
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // line store: read each pixel, result used on the group's last pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      store_rd <= partial_min_row[store_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && group_end) begin
      partial_min_row[store_idx] <= block_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (block.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_min  <= block_m + DEPTH_W'(1);
      out_last <= row_end && frame_row;
    end
  end

  assign block.valid         = out_valid;
  assign block.block_min     = out_min;
  assign block.last_of_frame = out_last;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 depth minimum downsampler. Pixel requests
// are driven in raster order with random gaps and random result stalls. A
// behavioural line-store model predicts each block minimum, and every result
// is checked field by field. The geometry is changed between phases, both on
// frame boundaries and part-way through a frame, including clamped values.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmd4_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 900;

  typedef struct packed {
    depth_t block_min;
    logic   last_of_frame;
  } block_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  cfg_reg_t              reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  dmd4_pixel_if pixel();
  dmd4_block_if block();

  depth_min_downsample_4x4 DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel        (pixel),
    .block        (block)
  );

  // pooling model state
  depth_t              line_min [STORE_DEPTH];
  int unsigned         store_span;
  depth_t              run_min;
  int unsigned         col_pos;
  int unsigned         row_in_quad;
  int unsigned         quad_row;
  logic [GROUPS_W-1:0] cfg_groups;
  logic [QUADS_W-1:0]  cfg_quads;
  logic                frame_closed;
  block_result_t       pending_blocks [$];

  int errors       = 0;
  int quiet_cycles = 0;
  int sink_stall   = 0;
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;

  always #1 clk = ~clk;

  function automatic int unsigned clamp_int(int unsigned v, int unsigned lo,
                                            int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic depth_t rand_depth(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 9))
      0: return depth_t'(1);
      1: return DEPTH_ALL_ONES;
      2: return depth_t'($urandom_range(1, 15));
      default: return depth_t'($urandom_range(1, 65535));
    endcase
  endfunction

  // zero maps to all ones, so minima are taken on (pixel - 1)
  function automatic void predict_pixel(depth_t px);
    int unsigned   width_px;
    int unsigned   quads;
    int unsigned   idx;
    depth_t        mapped;
    depth_t        m;
    block_result_t res;
    width_px = clamp_int(cfg_groups, 1, MAX_GROUPS) * 8;
    quads    = clamp_int(cfg_quads, 1, MAX_QUADS);
    mapped   = px - 16'd1;
    if (mapped < run_min) run_min = mapped;
    if (col_pos % 4 == 3) begin
      idx = (col_pos / 4) % STORE_DEPTH;
      m   = run_min;
      if (row_in_quad != 0 && line_min[idx] < m) m = line_min[idx];
      line_min[idx] = m;
      if (idx + 1 > store_span) store_span = idx + 1;
      run_min = DEPTH_ALL_ONES;
      if (row_in_quad == 3) begin
        res.block_min     = m + 16'd1;
        res.last_of_frame = (col_pos + 1 >= width_px) && (quad_row + 1 >= quads);
        if (res.last_of_frame) frame_closed = 1'b1;
        pending_blocks.push_back(res);
      end
    end
    if (col_pos + 1 >= width_px) begin
      col_pos = 0;
      run_min = DEPTH_ALL_ONES;
      if (row_in_quad >= 3) begin
        row_in_quad = 0;
        quad_row    = (quad_row + 1 >= quads) ? 0 : quad_row + 1;
      end else begin
        row_in_quad++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  task automatic send_pixel(depth_t value);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      pixel.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel.valid       <= 1'b1;
    pixel.depth_pixel <= value;
    // hold the request until it is taken
    do begin
      @(posedge clk);
    end while (!pixel.ready);
    predict_pixel(value);
  endtask

  task automatic settle();
    @(negedge clk);
    pixel.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index    <= which;
    write_data   <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    if (which == REG_WIDTH_IN_GROUPS) cfg_groups = value[GROUPS_W-1:0];
    else cfg_quads = value[QUADS_W-1:0];
  endtask

  task automatic test_reset_geometry();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    // part of the first row at reset width, then narrow to finish the quad
    repeat (100) send_pixel(rand_depth(50));
    settle();
    write_reg(REG_WIDTH_IN_GROUPS, 11'd1);
    repeat (1 + 3 * 8) send_pixel(rand_depth(50));
    settle();
  endtask

  task automatic test_directed_frame();
    depth_t value;
    // bit 10 is dropped, leaving zero: clamps to one group; height zero likewise
    write_reg(REG_WIDTH_IN_GROUPS, 11'h400);
    write_reg(REG_HEIGHT_IN_QUADS, '0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (c < 4) value = (r == 2 && c == 1) ? DEPTH_ALL_ONES : '0;
        else if (r == 1 && c == 6) value = depth_t'(1);
        else if (r == 3 && c == 7) value = DEPTH_ALL_ONES;
        else value = (r == 0) ? depth_t'(16'h8000) : '0;
        send_pixel(value);
      end
    end
    settle();
  endtask

  task automatic test_widest_row();
    write_reg(REG_WIDTH_IN_GROUPS, 11'h7FF);
    write_reg(REG_HEIGHT_IN_QUADS, 11'd2);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (200) send_pixel(rand_depth(10));
    settle();
    // narrow the rest of the quad
    write_reg(REG_WIDTH_IN_GROUPS, 11'd1);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (1 + 3 * 8) send_pixel(rand_depth(10));
    settle();
  endtask

  task automatic test_tallest_frame();
    write_reg(REG_HEIGHT_IN_QUADS, 11'h7FF);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (2 * 4 * 8) send_pixel(rand_depth(30));
    settle();
    // shorten the frame so the current quad row closes it
    write_reg(REG_HEIGHT_IN_QUADS, 11'd1);
    frame_closed = 1'b0;
    while (!frame_closed) send_pixel(rand_depth(30));
    settle();
  endtask

  task automatic test_random_traffic();
    int                    sent;
    int                    burst;
    int                    zero_pct;
    logic [CFG_DATA_W-1:0] value;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: zero_pct = 0;
        1: zero_pct = 10;
        2: zero_pct = 50;
        default: zero_pct = 97;
      endcase
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(10, 120);
      repeat (burst) send_pixel(rand_depth(zero_pct));
      sent += burst;
      case ($urandom_range(0, 2))
        0: ;
        1: settle();
        default: begin
          settle();
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
              0: value = '0;
              1: value = 11'h400 | 11'($urandom_range(1, 3));
              2, 3: value = 11'($urandom_range(5, 16));
              default: value = 11'($urandom_range(1, 4));
            endcase
            // mid-quad, stay within line-store entries already filled
            if (row_in_quad != 0 &&
                2 * clamp_int(value[GROUPS_W-1:0], 1, MAX_GROUPS) > store_span)
              value = 11'd1;
            write_reg(REG_WIDTH_IN_GROUPS, value);
          end
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
              0: value = '0;
              1: value = 11'd1024;
              2: value = 11'h7FF;
              3: value = 11'($urandom_range(5, 12));
              default: value = 11'($urandom_range(1, 4));
            endcase
            write_reg(REG_HEIGHT_IN_QUADS, value);
          end
        end
      endcase
    end
    settle();
  endtask

  always @(negedge clk) begin
    if (sink_stall == 0) begin
      block.ready <= 1'b1;
    end else begin
      block.ready <= 1'b0;
      if (block.valid) sink_stall--;
    end
  end

  always @(posedge clk) begin : result_check
    block_result_t want;
    if ((pixel.valid && pixel.ready) || (block.valid && block.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (!rst && block.valid && block.ready) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected block result: block_min %h", block.block_min);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        if (block.block_min !== want.block_min) begin
          $error("block_min: expected %h, got %h", want.block_min, block.block_min);
          errors++;
        end
        if (block.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %b, got %b", want.last_of_frame,
                 block.last_of_frame);
          errors++;
        end
      end
      sink_stall = sink_idle_on ? $urandom_range(0, 9) : 0;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    write_enable      = 1'b0;
    reg_index         = REG_WIDTH_IN_GROUPS;
    write_data        = '0;
    pixel.valid       = 1'b0;
    pixel.depth_pixel = '0;
    block.ready       = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) line_min[i] = '0;
    store_span   = 0;
    run_min      = DEPTH_ALL_ONES;
    col_pos      = 0;
    row_in_quad  = 0;
    quad_row     = 0;
    cfg_groups   = GROUPS_RESET;
    cfg_quads    = QUADS_RESET;
    frame_closed = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_directed_frame();
    test_widest_row();
    test_tallest_frame();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
